// File: hw/rtl/ioq_pkg.sv
// shared types and constants for the interval overlap query block
// no dependencies; imported by every module of the block but ioq_ram
`default_nettype none
package ioq_pkg;

  // field widths of the stream beats
  localparam int unsigned CHROM_BITS = 8;
  localparam int unsigned COORD_BITS = 31;
  localparam int unsigned OP_BITS    = 2;
  localparam int unsigned STAT_BITS  = 2;
  localparam int unsigned CNT_OUT_W  = 11;
  localparam int unsigned RANK_OUT_W = 10;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned FRAC_FRAC  = 16;
  localparam int unsigned BASES_W    = 32;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 248;

  // saturation limits
  localparam logic [CNT_OUT_W-1:0]  CNT_MAX   = '1;
  localparam logic [RANK_OUT_W-1:0] RANK_MAX  = '1;
  localparam logic [COORD_BITS-1:0] LEN_MAX   = '1;
  localparam logic [BASES_W-1:0]    BASES_MAX = '1;
  localparam logic [FRAC_W-1:0]     FRAC_MAX  = '1;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_QUERY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  // stored entry: chrom id, start, end
  typedef struct packed {
    logic [CHROM_BITS-1:0] chrom;
    logic [COORD_BITS-1:0] start;
    logic [COORD_BITS-1:0] stop;
  } entry_t;

  // request to the shared divider
  typedef struct packed {
    logic go;
    logic busy;
  } div_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/ioq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module ioq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ioq_div.sv
// shared restoring divider: q = min((num << 16) / den, 0xffffff), one bit a cycle
// depends on ioq_pkg
`default_nettype none
module ioq_div #(
  parameter int unsigned NUM_W = 48
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [NUM_W-1:0]          num,
  input  wire logic [NUM_W-1:0]          den,
  output logic                           done,
  output logic [ioq_pkg::FRAC_W-1:0]     quot
);
  import ioq_pkg::*;

  localparam int unsigned CW = $clog2(FRAC_W);

  logic [NUM_W:0]          rem;
  logic [NUM_W-1:0]        dreg;
  logic [7:0]              nlow;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic [NUM_W:0]          trial;
  logic                    nbit;
  logic                    fits;
  logic                    over;

  // next dividend bit: num low byte sits at quotient bits 23..16
  always_comb begin
    nbit  = (cnt >= CW'(FRAC_FRAC)) ? nlow[3'(cnt - CW'(FRAC_FRAC))] : 1'b0;
    trial = {rem[NUM_W-1:0], nbit};
    fits  = trial >= {1'b0, dreg};
    over  = {8'd0, num} >= {den, 8'd0};
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dreg <= den;
        nlow <= num[7:0];
        cnt  <= CW'(FRAC_W - 1);
        rem  <= {9'd0, num[NUM_W-1:8]};
        quot <= '0;
        if (den == '0) begin
          done <= 1'b1;
        end else if (over) begin
          quot <= FRAC_MAX;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= fits ? trial - {1'b0, dreg} : trial;
        quot <= {quot[FRAC_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/interval_overlap_query_top.sv
// interval overlap query block: entry table, scan pipeline and result sequencer
// depends on ioq_pkg, ioq_ram, ioq_div
//
// Input beats carry a command in s_tuser: load an interval into the table,
// clear the table, or query an interval against every stored entry. Each
// input beat gives exactly one output beat with its status in m_tuser.
// Loads, clears, rejected and unused commands answer in the cycle after the
// beat is taken. A query streams the table out of one RAM read port, one
// entry a cycle, through a two-stage overlap pipeline; if any entry matched,
// it then runs four 24-step divisions on one shared divider. The block takes
// no new beat while a query runs. A finished result sits in an output
// register; the next beat is accepted as soon as that register is free or
// being drained. When m_tready stays low the result holds and s_tready stays
// low. Reset empties the table (entry count to zero) and drops any pending
// result; the RAM is not cleared.
`default_nettype none
module interval_overlap_query_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // chrom_id, interval_start, interval_end, zero pad
  input  wire logic [ioq_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode
  input  wire logic [ioq_pkg::OP_BITS-1:0]     s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // match_count, best_overlap, best_rank, best_query_fraction, best_db_fraction,
  // query_cover_fraction, db_cover_fraction, matched_bases, start_offset,
  // end_offset, zero pad
  output logic [ioq_pkg::OUT_DATA_W-1:0]       m_tdata,
  // status
  output logic [ioq_pkg::STAT_BITS-1:0]        m_tuser
);
  import ioq_pkg::*;

  localparam int unsigned ADDR_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OV_W   = COORD_BITS + 1;
  localparam int unsigned SUM_W  = OV_W + CNT_W;
  localparam int unsigned ENT_W  = CHROM_BITS + 2 * COORD_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_DIV, S_DONE} state_t;

  state_t state;

  // input beat fields
  logic [CHROM_BITS-1:0] in_chrom;
  logic [COORD_BITS-1:0] in_start;
  logic [COORD_BITS-1:0] in_end;
  opcode_t               in_op;
  logic                  s_fire;
  logic                  bad_order;

  assign in_chrom  = s_tdata[CHROM_BITS-1:0];
  assign in_start  = s_tdata[CHROM_BITS +: COORD_BITS];
  assign in_end    = s_tdata[CHROM_BITS+COORD_BITS +: COORD_BITS];
  assign in_op     = opcode_t'(s_tuser);
  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign s_fire    = s_tvalid && s_tready;
  assign bad_order = in_end < in_start;

  logic [CNT_W-1:0] entry_count;
  logic             table_full;
  logic             load_wr;

  assign table_full = entry_count == CNT_W'(TABLE_DEPTH);
  assign load_wr    = s_fire && (in_op == OP_LOAD) && !bad_order && !table_full;

  // query registers
  logic [CHROM_BITS-1:0] q_chrom;
  logic [COORD_BITS-1:0] q_start;
  logic [COORD_BITS-1:0] q_end;
  logic [OV_W-1:0]       q_len;

  // scan read side
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_en;
  entry_t           rd_ent;
  logic [ENT_W-1:0] rd_raw;
  logic             v1;

  assign rd_en  = (state == S_SCAN) && (rd_cnt != entry_count);
  assign rd_ent = entry_t'(rd_raw);

  ioq_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr(entry_count[ADDR_W-1:0]),
    .wr_data({in_chrom, in_start, in_end}),
    .rd_en  (rd_en),
    .rd_addr(rd_cnt[ADDR_W-1:0]),
    .rd_data(rd_raw)
  );

  // overlap stage
  logic [COORD_BITS-1:0] lo;
  logic [COORD_BITS-1:0] hi;
  logic                  hit;
  logic                  v2;
  logic [OV_W-1:0]       ov2;
  logic [OV_W-1:0]       elen2;
  logic [COORD_BITS-1:0] es2;
  logic [COORD_BITS-1:0] ee2;

  always_comb begin
    lo  = (rd_ent.start > q_start) ? rd_ent.start : q_start;
    hi  = (rd_ent.stop < q_end) ? rd_ent.stop : q_end;
    hit = (rd_ent.chrom == q_chrom) && (hi >= lo);
  end

  always_ff @(posedge clk) begin
    ov2   <= hit ? OV_W'(hi) - OV_W'(lo) + 1'b1 : '0;
    elen2 <= OV_W'(rd_ent.stop) - OV_W'(rd_ent.start) + 1'b1;
    es2   <= rd_ent.start;
    ee2   <= rd_ent.stop;
  end

  // accumulators
  logic [CNT_W-1:0]      match_cnt;
  logic [OV_W-1:0]       best;
  logic [CNT_W-1:0]      rank;
  logic [OV_W-1:0]       best_len;
  logic [COORD_BITS-1:0] best_s;
  logic [COORD_BITS-1:0] best_e;
  logic [SUM_W-1:0]      sum_ov;
  logic [SUM_W-1:0]      sum_len;
  logic                  q_start_pulse;

  assign q_start_pulse = s_fire && (in_op == OP_QUERY) && !bad_order;

  always_ff @(posedge clk) begin
    if (q_start_pulse) begin
      q_chrom   <= in_chrom;
      q_start   <= in_start;
      q_end     <= in_end;
      q_len     <= OV_W'(in_end) - OV_W'(in_start) + 1'b1;
      match_cnt <= '0;
      best      <= '0;
      rank      <= '0;
      best_len  <= '0;
      best_s    <= '0;
      best_e    <= '0;
      sum_ov    <= '0;
      sum_len   <= '0;
    end else if (v2 && (ov2 != '0)) begin
      match_cnt <= match_cnt + 1'b1;
      sum_ov    <= sum_ov + SUM_W'(ov2);
      sum_len   <= sum_len + SUM_W'(elen2);
      if (ov2 > best) begin
        best     <= ov2;
        rank     <= match_cnt;
        best_len <= elen2;
        best_s   <= es2;
        best_e   <= ee2;
      end
    end
  end

  // shared divider operands
  logic [1:0]        div_sel;
  logic              div_pend;
  logic              div_go;
  logic              div_done;
  logic [FRAC_W-1:0] div_q;
  logic [SUM_W-1:0]  div_num;
  logic [SUM_W-1:0]  div_den;
  logic [FRAC_W-1:0] frac [4];

  assign div_go = (state == S_DIV) && !div_pend;

  always_comb begin
    div_num = div_sel[1] ? sum_ov : SUM_W'(best);
    case (div_sel)
      2'd1:    div_den = SUM_W'(best_len);
      2'd3:    div_den = sum_len;
      default: div_den = SUM_W'(q_len);
    endcase
  end

  ioq_div #(.NUM_W(SUM_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      frac[div_sel] <= div_q;
    end
  end

  // result fields of a query
  logic [CNT_OUT_W-1:0]  r_count;
  logic [COORD_BITS-1:0] r_best;
  logic [RANK_OUT_W-1:0] r_rank;
  logic [BASES_W-1:0]    r_bases;
  logic [COORD_BITS-1:0] r_soff;
  logic [COORD_BITS-1:0] r_eoff;
  logic [OUT_DATA_W-1:0] q_data;

  always_comb begin
    r_count = (match_cnt > CNT_W'(CNT_MAX)) ? CNT_MAX : CNT_OUT_W'(match_cnt);
    r_best  = best[OV_W-1] ? LEN_MAX : best[COORD_BITS-1:0];
    r_rank  = (rank > CNT_W'(RANK_MAX)) ? RANK_MAX : RANK_OUT_W'(rank);
    r_bases = (sum_len > SUM_W'(BASES_MAX)) ? BASES_MAX : BASES_W'(sum_len);
    r_soff  = (best_s > q_start) ? best_s - q_start : q_start - best_s;
    r_eoff  = (best_e > q_end) ? best_e - q_end : q_end - best_e;
    q_data  = '0;
    if (match_cnt != '0) begin
      q_data[241:0] = {r_eoff, r_soff, r_bases, frac[3], frac[2], frac[1], frac[0],
                       r_rank, r_best, r_count};
    end
  end

  // output register takes a new beat this cycle
  logic out_load;

  assign out_load = (state == S_IDLE) ? (s_fire && !q_start_pulse)
                                      : ((state == S_DONE) && (!m_tvalid || m_tready));

  // sequencer, scan pipeline valids and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_cnt      <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      div_sel     <= '0;
      div_pend    <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tuser     <= ST_OK;
      m_tdata     <= '0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            m_tdata <= '0;
            if (in_op == OP_CLEAR) begin
              entry_count <= '0;
              m_tvalid    <= 1'b1;
              m_tuser     <= ST_OK;
            end else if (in_op == OP_UNUSED) begin
              m_tvalid <= 1'b1;
              m_tuser  <= ST_OK;
            end else if (bad_order) begin
              m_tvalid <= 1'b1;
              m_tuser  <= ST_REJECT;
            end else if (in_op == OP_LOAD) begin
              m_tvalid <= 1'b1;
              if (table_full) begin
                m_tuser <= ST_FULL;
              end else begin
                m_tuser     <= ST_OK;
                entry_count <= entry_count + 1'b1;
              end
            end else begin
              rd_cnt <= '0;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            div_sel  <= '0;
            div_pend <= 1'b0;
            state    <= (match_cnt == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (div_go) begin
            div_pend <= 1'b1;
          end else if (div_done) begin
            div_pend <= 1'b0;
            if (div_sel == 2'd3) begin
              state <= S_DONE;
            end else begin
              div_sel <= div_sel + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_QUERY;
            m_tdata  <= q_data;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ioq_checker.sv
// port-level checks for the interval overlap query block, bound to the top
// depends on ioq_pkg and interval_overlap_query_top
`default_nettype none
module ioq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [ioq_pkg::IN_DATA_W-1:0] s_tdata,
  input wire logic [ioq_pkg::OP_BITS-1:0]   s_tuser,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [ioq_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [ioq_pkg::STAT_BITS-1:0] m_tuser
);
  import ioq_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // non-query results carry only a status
  a_plain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_QUERY) |-> m_tdata == '0)
    else $error("non-query result with nonzero fields");

  // a query with no match reports all zeros
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_QUERY) && (m_tdata[10:0] == '0) |-> m_tdata == '0)
    else $error("query without match has nonzero fields");

  // a valid query keeps the input closed on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_QUERY) &&
    (s_tdata[69:39] >= s_tdata[38:8]) |=> !s_tready)
    else $error("input open while a query runs");

endmodule

bind interval_overlap_query_top ioq_checker u_ioq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
`default_nettype wire

// File: verif/tb_interval_overlap_query_top.sv
// self-checking testbench for the interval overlap query block
// depends on ioq_pkg and interval_overlap_query_top; predicts each result beat
`default_nettype none
module tb_interval_overlap_query_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ioq_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam longint unsigned CYCLE_CAP = 3000000;
  localparam int unsigned SETTLE       = 1300;  // full-table scan plus divider

  typedef struct packed {
    status_t                 status;
    logic [CNT_OUT_W-1:0]    match_count;
    logic [COORD_BITS-1:0]   best_overlap;
    logic [RANK_OUT_W-1:0]   best_rank;
    logic [FRAC_W-1:0]       best_query_fraction;
    logic [FRAC_W-1:0]       best_db_fraction;
    logic [FRAC_W-1:0]       query_cover_fraction;
    logic [FRAC_W-1:0]       db_cover_fraction;
    logic [BASES_W-1:0]      matched_bases;
    logic [COORD_BITS-1:0]   start_offset;
    logic [COORD_BITS-1:0]   end_offset;
  } overlap_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [OP_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_BITS-1:0] m_tuser;

  interval_overlap_query_top #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // shadow copy of the interval table
  logic [CHROM_BITS-1:0] tbl_chrom [DEPTH];
  logic [COORD_BITS-1:0] tbl_start [DEPTH];
  logic [COORD_BITS-1:0] tbl_end [DEPTH];
  int unsigned tbl_count = 0;

  overlap_report_t pending_reports [$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req_len = 0;
  int unsigned hold_req_seq = 0;
  longint unsigned cycle_cnt = 0;

  function automatic longint unsigned sat64(longint unsigned v, longint unsigned mx);
    return (v > mx) ? mx : v;
  endfunction

  function automatic longint unsigned q16_ratio(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return sat64((num << 16) / den, 64'hFF_FFFF);
  endfunction

  // computes the report for one command and updates the shadow table
  function automatic overlap_report_t overlap_report(opcode_t op, logic [CHROM_BITS-1:0] chr,
                                                     logic [COORD_BITS-1:0] qs,
                                                     logic [COORD_BITS-1:0] qe);
    overlap_report_t r;
    longint unsigned qlen, hits, best, rank, best_len, best_s, best_e, sum_ov, sum_len;
    longint unsigned lo, hi, ov;
    r = '0;
    r.status = ST_OK;
    if (op == OP_CLEAR) begin
      tbl_count = 0;
      return r;
    end
    if (op == OP_UNUSED) return r;
    if (qe < qs) begin
      r.status = ST_REJECT;
      return r;
    end
    if (op == OP_LOAD) begin
      if (tbl_count >= DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      tbl_chrom[tbl_count] = chr;
      tbl_start[tbl_count] = qs;
      tbl_end[tbl_count] = qe;
      tbl_count++;
      return r;
    end
    r.status = ST_QUERY;
    qlen = qe - qs + 1;
    hits = 0; best = 0; rank = 0; best_len = 0; best_s = 0; best_e = 0;
    sum_ov = 0; sum_len = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_chrom[i] != chr) continue;
      lo = (tbl_start[i] > qs) ? tbl_start[i] : qs;
      hi = (tbl_end[i] < qe) ? tbl_end[i] : qe;
      if (hi < lo) continue;
      ov = hi - lo + 1;
      hits++;
      sum_ov += ov;
      sum_len += tbl_end[i] - tbl_start[i] + 1;
      if (ov > best) begin
        best = ov;
        rank = hits - 1;
        best_len = tbl_end[i] - tbl_start[i] + 1;
        best_s = tbl_start[i];
        best_e = tbl_end[i];
      end
    end
    if (hits == 0) return r;
    r.match_count          = CNT_OUT_W'(sat64(hits, 2047));
    r.best_overlap         = COORD_BITS'(sat64(best, 64'h7FFF_FFFF));
    r.best_rank            = RANK_OUT_W'(sat64(rank, 1023));
    r.best_query_fraction  = FRAC_W'(q16_ratio(best, qlen));
    r.best_db_fraction     = FRAC_W'(q16_ratio(best, best_len));
    r.query_cover_fraction = FRAC_W'(q16_ratio(sum_ov, qlen));
    r.db_cover_fraction    = FRAC_W'(q16_ratio(sum_ov, sum_len));
    r.matched_bases        = BASES_W'(sat64(sum_len, 64'hFFFF_FFFF));
    r.start_offset = COORD_BITS'(sat64((best_s > qs) ? best_s - qs : qs - best_s,
                                       64'h7FFF_FFFF));
    r.end_offset   = COORD_BITS'(sat64((best_e > qe) ? best_e - qe : qe - best_e,
                                       64'h7FFF_FFFF));
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls plus requested long hold-offs
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req_seq) begin
      hold_seen <= hold_req_seq;
      hold_left <= hold_req_len;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic chk(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    overlap_report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        e = pending_reports.pop_front();
        chk("status", e.status, m_tuser);
        chk("match_count", e.match_count, m_tdata[10:0]);
        chk("best_overlap", e.best_overlap, m_tdata[41:11]);
        chk("best_rank", e.best_rank, m_tdata[51:42]);
        chk("best_query_fraction", e.best_query_fraction, m_tdata[75:52]);
        chk("best_db_fraction", e.best_db_fraction, m_tdata[99:76]);
        chk("query_cover_fraction", e.query_cover_fraction, m_tdata[123:100]);
        chk("db_cover_fraction", e.db_cover_fraction, m_tdata[147:124]);
        chk("matched_bases", e.matched_bases, m_tdata[179:148]);
        chk("start_offset", e.start_offset, m_tdata[210:180]);
        chk("end_offset", e.end_offset, m_tdata[241:211]);
        chk("pad", 0, m_tdata[247:242]);
      end
    end
  end

  // send one command beat, with an optional random gap first
  task automatic send_beat(opcode_t op, logic [CHROM_BITS-1:0] chr,
                           logic [COORD_BITS-1:0] qs, logic [COORD_BITS-1:0] qe);
    overlap_report_t rep;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tuser <= op;
    s_tdata <= {2'b00, qe, qs, chr};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    rep = overlap_report(op, chr, qs, qe);
    pending_reports = {pending_reports, rep};
  endtask

  // stop sending until every prediction is matched, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom() & 32'h7FFF_FFFF);
  endfunction

  task automatic test_empty_and_odd_ops();
    send_beat(OP_QUERY, 8'd0, 31'd0, 31'h7FFF_FFFF);
    send_beat(OP_UNUSED, 8'hFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_beat(OP_CLEAR, 8'hFF, 31'h7FFF_FFFF, 31'd0);
    send_beat(OP_LOAD, 8'd3, 31'd10, 31'd9);       // end before start
    send_beat(OP_QUERY, 8'd3, 31'h7FFF_FFFF, 31'd0);
    drain();
  endtask

  task automatic test_directed_overlaps();
    send_beat(OP_LOAD, 8'hFF, 31'd0, 31'h7FFF_FFFF);
    send_beat(OP_LOAD, 8'd0, 31'd100, 31'd199);
    send_beat(OP_LOAD, 8'd0, 31'd150, 31'd249);   // same overlap as previous: tie
    send_beat(OP_LOAD, 8'd0, 31'd120, 31'd120);
    send_beat(OP_LOAD, 8'd1, 31'd100, 31'd199);   // other chromosome
    send_beat(OP_LOAD, 8'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_beat(OP_QUERY, 8'hFF, 31'd0, 31'h7FFF_FFFF);
    send_beat(OP_QUERY, 8'hFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_beat(OP_QUERY, 8'd0, 31'd150, 31'd199);
    send_beat(OP_QUERY, 8'd0, 31'd0, 31'h7FFF_FFFF);
    send_beat(OP_QUERY, 8'd0, 31'd120, 31'd120);
    send_beat(OP_QUERY, 8'd0, 31'd300, 31'd400);  // no match
    send_beat(OP_QUERY, 8'd2, 31'd100, 31'd199);  // no entry on chromosome
    send_beat(OP_QUERY, 8'd1, 31'd199, 31'd500);
    send_beat(OP_QUERY, 8'd0, 31'd50, 31'd100);
    send_beat(OP_CLEAR, 8'd0, 31'd0, 31'd0);
    send_beat(OP_QUERY, 8'd0, 31'd100, 31'd199);
    drain();
  endtask

  task automatic test_table_full();
    logic [COORD_BITS-1:0] s;
    send_beat(OP_CLEAR, 8'd0, 31'd0, 31'd0);
    for (int i = 0; i < DEPTH; i++) begin
      s = COORD_BITS'($urandom_range(5000));
      send_beat(OP_LOAD, CHROM_BITS'($urandom_range(1)), s,
                s + COORD_BITS'($urandom_range(300)));
    end
    send_beat(OP_LOAD, 8'd0, 31'd10, 31'd20);     // dropped
    send_beat(OP_LOAD, 8'd0, 31'd20, 31'd10);     // rejected before full check
    send_beat(OP_QUERY, 8'd0, 31'd0, 31'h7FFF_FFFF);
    send_beat(OP_QUERY, 8'd1, 31'd2000, 31'd2100);
    send_beat(OP_CLEAR, 8'd0, 31'd0, 31'd0);
    drain();
  endtask

  // mostly well-formed load/query traffic on a small table, some noise
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned roll;
    logic [COORD_BITS-1:0] s, e;
    logic [CHROM_BITS-1:0] c;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      c = CHROM_BITS'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3));
      if ($urandom_range(7) == 0) begin
        s = rand_coord();
        e = rand_coord();
        if ($urandom_range(3) != 0 && e < s) {s, e} = {e, s};
      end else begin
        s = COORD_BITS'(32'h4000_0000 + $urandom_range(2000));
        e = s + COORD_BITS'($urandom_range(600));
      end
      if (roll < 3) send_beat(OP_UNUSED, c, s, e);
      else if (roll < 6 || (tbl_count > 40 && roll < 12)) send_beat(OP_CLEAR, c, s, e);
      else if (roll < 9) send_beat(($urandom_range(1) != 0) ? OP_LOAD : OP_QUERY, c, e, s);
      else if (roll < 55) send_beat(OP_LOAD, c, s, e);
      else send_beat(OP_QUERY, c, s, e);
    end
    drain();
  endtask

  task automatic test_backpressure();
    logic [COORD_BITS-1:0] s;
    hold_req_len = 800;
    hold_req_seq++;
    for (int i = 0; i < 20; i++) begin
      s = COORD_BITS'($urandom_range(1000));
      send_beat(($urandom_range(2) == 0) ? OP_QUERY : OP_LOAD, 8'd5, s,
                s + COORD_BITS'($urandom_range(200)));
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_odd_ops();
    test_directed_overlaps();
    test_table_full();
    idle_pct = 0;  stall_pct = 0;  test_random_traffic(135);
    idle_pct = 83; stall_pct = 0;  test_random_traffic(135);
    idle_pct = 0;  stall_pct = 83; test_random_traffic(135);
    idle_pct = 19; stall_pct = 19; test_random_traffic(135);
    idle_pct = 0;  stall_pct = 0;  test_backpressure();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/ioq_pkg.sv
hw/rtl/ioq_ram.sv
hw/rtl/ioq_div.sv
hw/rtl/interval_overlap_query_top.sv
hw/rtl/ioq_checker.sv
verif/tb_interval_overlap_query_top.sv
